// File: rtl/uer_pkg.sv
// Shared types and constants for the ultrasonic echo ranger.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package uer_pkg;

  // Burst sequencer phases
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_TRIG = 2'd1,
    PH_WAIT = 2'd2,
    PH_MEAS = 2'd3
  } phase_e;

  // Configuration register indexes
  typedef enum logic {
    CFG_NEAR_THRESHOLD = 1'b0,
    CFG_TRIGGER_TICKS  = 1'b1
  } cfg_idx_e;

  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned THRESH_W    = 16;
  localparam int unsigned TICKS_W     = 8;
  localparam int unsigned SAMP_W      = 3;
  localparam int unsigned CM_W        = 15;
  localparam int unsigned HUND_W      = 7;
  localparam int unsigned CM_MAX      = 32767;
  localparam int unsigned THR_MILLI_W = 26;
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 32;

  localparam logic [THRESH_W-1:0] THRESH_RST = 16'd20;
  localparam logic [TICKS_W-1:0]  TICKS_RST  = 8'd15;

  // Per-tick flags handed from the sequencer to the scaling pipeline
  typedef struct packed {
    logic trigger;
    logic result;
    logic saturated;
  } flags_t;

endpackage

// File: rtl/uer_ctrl.sv
// Burst sequencer: trigger timing, echo width counting and width summing.
// Depends on uer_pkg. Produces one registered flags/sum request per tick.
`timescale 1ns / 1ps

module uer_ctrl #(
  parameter int unsigned SAMPLES    = 5,
  parameter int unsigned WIDTH_BITS = 20,
  localparam int unsigned SUM_W     = WIDTH_BITS + 3
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [uer_pkg::TICKS_W-1:0]   trigger_ticks_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          echo_level_i,
  input  logic                          start_request_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output uer_pkg::flags_t               out_flags_o,
  output logic [SUM_W-1:0]              out_sum_o
);
  import uer_pkg::*;

  localparam logic [WIDTH_BITS-1:0] WMAX = {WIDTH_BITS{1'b1}};

  phase_e                phase_q, phase_d;
  logic [TICKS_W-1:0]    cnt_q, cnt_d, cnt_inc, len;
  logic [WIDTH_BITS-1:0] pw_q, pw_d;
  logic [SUM_W-1:0]      sum_q, sum_d, sum_new;
  logic [SAMP_W-1:0]     samp_q, samp_d, samp_inc;
  logic                  sat_q, sat_d;
  flags_t                res_flags;
  logic [SUM_W-1:0]      res_sum;
  logic                  fire;

  logic                  o_valid_q;
  flags_t                o_flags_q;
  logic [SUM_W-1:0]      o_sum_q;

  assign in_ready_o = !o_valid_q || out_ready_i;
  assign fire       = in_valid_i && in_ready_o;
  assign len        = (trigger_ticks_i == '0) ? TICKS_W'(1) : trigger_ticks_i;
  assign cnt_inc    = cnt_q + TICKS_W'(1);
  assign samp_inc   = samp_q + SAMP_W'(1);
  assign sum_new    = sum_q + SUM_W'(pw_q);

  // Next state and per-tick result
  always_comb begin
    phase_d   = phase_q;
    cnt_d     = cnt_q;
    pw_d      = pw_q;
    sum_d     = sum_q;
    samp_d    = samp_q;
    sat_d     = sat_q;
    res_flags = '0;
    res_sum   = '0;
    unique case (phase_q)
      PH_IDLE: begin
        if (start_request_i) begin
          phase_d = PH_TRIG;
          cnt_d   = '0;
          pw_d    = '0;
          sum_d   = '0;
          samp_d  = '0;
          sat_d   = 1'b0;
        end
      end
      PH_TRIG: begin
        res_flags.trigger = 1'b1;
        cnt_d = cnt_inc;
        if (cnt_inc >= len || cnt_inc == '0) begin
          phase_d = PH_WAIT;
        end
      end
      PH_WAIT: begin
        if (echo_level_i) begin
          pw_d    = WIDTH_BITS'(1);
          phase_d = PH_MEAS;
        end
      end
      PH_MEAS: begin
        if (echo_level_i) begin
          // width holds at the counter maximum
          if (pw_q != WMAX) begin
            pw_d = pw_q + WIDTH_BITS'(1);
          end
          if (pw_q >= WMAX - WIDTH_BITS'(1)) begin
            sat_d = 1'b1;
          end
        end else begin
          pw_d  = '0;
          cnt_d = '0;
          if (samp_inc >= SAMP_W'(SAMPLES) || samp_inc == '0) begin
            // last pulse of the burst: report and go idle
            res_flags.result    = 1'b1;
            res_flags.saturated = sat_q;
            res_sum             = sum_new;
            phase_d = PH_IDLE;
            sum_d   = '0;
            samp_d  = '0;
            sat_d   = 1'b0;
          end else begin
            sum_d   = sum_new;
            samp_d  = samp_inc;
            phase_d = PH_TRIG;
          end
        end
      end
      default: phase_d = PH_IDLE;
    endcase
  end

  // Sequencer state, advanced once per accepted tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cnt_q   <= '0;
      pw_q    <= '0;
      sum_q   <= '0;
      samp_q  <= '0;
      sat_q   <= 1'b0;
    end else if (fire) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      pw_q    <= pw_d;
      sum_q   <= sum_d;
      samp_q  <= samp_d;
      sat_q   <= sat_d;
    end
  end

  // Output stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      o_valid_q <= in_valid_i;
    end
  end

  // Output stage payload
  always_ff @(posedge clk_i) begin
    if (fire) begin
      o_flags_q <= res_flags;
      o_sum_q   <= res_sum;
    end
  end

  assign out_valid_o = o_valid_q;
  assign out_flags_o = o_flags_q;
  assign out_sum_o   = o_sum_q;

endmodule

// File: rtl/uer_scale.sv
// Scaling pipeline: average, distance in cm, hundredths and near flag.
// Depends on uer_pkg. Four registered stages with per-stage handshake.
`timescale 1ns / 1ps

module uer_scale #(
  parameter int unsigned SAMPLES    = 5,
  parameter int unsigned WIDTH_BITS = 20,
  localparam int unsigned SUM_W     = WIDTH_BITS + 3
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [uer_pkg::THRESH_W-1:0]  near_threshold_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  uer_pkg::flags_t               in_flags_i,
  input  logic [SUM_W-1:0]              in_sum_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          trigger_level_o,
  output logic                          result_valid_o,
  output logic [uer_pkg::CM_W-1:0]      distance_cm_o,
  output logic [uer_pkg::HUND_W-1:0]    distance_hundredths_o,
  output logic                          near_flag_o,
  output logic                          width_saturated_o
);
  import uer_pkg::*;

  // average = sum / SAMPLES by reciprocal multiply
  localparam int unsigned AVG_SH   = SUM_W + 3;
  localparam int unsigned AVG_M_W  = AVG_SH + 1;
  localparam logic [63:0] AVG_M    =
    ((64'd1 << AVG_SH) + 64'(SAMPLES) - 64'd1) / 64'(SAMPLES);
  localparam int unsigned AVG_P_W  = SUM_W + AVG_M_W;

  // thousandths of a cm = avg * 17
  localparam int unsigned MILLI_W  = WIDTH_BITS + 5;

  // cm = milli / 1000
  localparam int unsigned CM_SH    = MILLI_W + 10;
  localparam int unsigned CM_M_W   = MILLI_W + 1;
  localparam logic [63:0] CM_M     = ((64'd1 << CM_SH) + 64'd999) / 64'd1000;
  localparam int unsigned CM_P_W   = MILLI_W + CM_M_W;
  localparam int unsigned CMR_W    = MILLI_W - 9;
  localparam int unsigned CMX_W    = (CMR_W > CM_W) ? CMR_W : CM_W;

  // hundredths-scale value = milli / 10
  localparam int unsigned CEN_SH   = MILLI_W + 4;
  localparam int unsigned CEN_M_W  = MILLI_W + 1;
  localparam logic [63:0] CEN_M    = ((64'd1 << CEN_SH) + 64'd9) / 64'd10;
  localparam int unsigned CEN_P_W  = MILLI_W + CEN_M_W;
  localparam int unsigned CEN_W    = MILLI_W - 3;

  localparam int unsigned CMP_W    = (MILLI_W > THR_MILLI_W) ? MILLI_W : THR_MILLI_W;

  logic rdy1, rdy2, rdy3, rdy4;
  logic v1_q, v2_q, v3_q, v4_q;

  flags_t                 f1_q, f2_q, f3_q;
  logic [WIDTH_BITS-1:0]  avg1_q;
  logic [THR_MILLI_W-1:0] thr1_q, thr2_q;
  logic [MILLI_W-1:0]     milli2_q;
  logic [CMR_W-1:0]       cm3_q;
  logic [CEN_W-1:0]       cen3_q;
  logic                   near3_q;

  logic [AVG_P_W-1:0]     avg_prod;
  logic [CM_P_W-1:0]      cm_prod;
  logic [CEN_P_W-1:0]     cen_prod;
  logic [MILLI_W-1:0]     milli;
  logic [CMX_W-1:0]       cm_ext;
  logic [CM_W-1:0]        cm_sat;
  logic [CEN_W-1:0]       hund_full;

  logic                   trig4_q, res4_q, near4_q, sat4_q;
  logic [CM_W-1:0]        cm4_q;
  logic [HUND_W-1:0]      hund4_q;

  // Stage handshake: a stage moves when its successor is empty or moving
  assign rdy4       = !v4_q || out_ready_i;
  assign rdy3       = !v3_q || rdy4;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  // Stage 1: divide by sample count, scale threshold to thousandths
  assign avg_prod = AVG_P_W'(in_sum_i) * AVG_P_W'(AVG_M[AVG_M_W-1:0]);

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      f1_q   <= in_flags_i;
      avg1_q <= avg_prod[AVG_SH +: WIDTH_BITS];
      thr1_q <= THR_MILLI_W'(near_threshold_i) * THR_MILLI_W'(1000);
    end
  end

  // Stage 2: avg * 17 as shift and add
  assign milli = (MILLI_W'(avg1_q) << 4) + MILLI_W'(avg1_q);

  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      f2_q     <= f1_q;
      milli2_q <= milli;
      thr2_q   <= thr1_q;
    end
  end

  // Stage 3: cm and milli/10 by reciprocal multiply, near compare
  assign cm_prod  = CM_P_W'(milli2_q) * CM_P_W'(CM_M[CM_M_W-1:0]);
  assign cen_prod = CEN_P_W'(milli2_q) * CEN_P_W'(CEN_M[CEN_M_W-1:0]);

  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) begin
      f3_q    <= f2_q;
      cm3_q   <= cm_prod[CM_SH +: CMR_W];
      cen3_q  <= cen_prod[CEN_SH +: CEN_W];
      near3_q <= CMP_W'(milli2_q) <= CMP_W'(thr2_q);
    end
  end

  // Stage 4: saturate cm, hundredths = milli/10 - cm*100, zero when no result
  assign cm_ext    = CMX_W'(cm3_q);
  assign cm_sat    = (cm_ext > CMX_W'(CM_MAX)) ? CM_W'(CM_MAX) : cm_ext[CM_W-1:0];
  assign hund_full = cen3_q - CEN_W'(cm3_q) * CEN_W'(100);

  always_ff @(posedge clk_i) begin
    if (rdy4 && v3_q) begin
      trig4_q <= f3_q.trigger;
      res4_q  <= f3_q.result;
      if (f3_q.result) begin
        cm4_q   <= cm_sat;
        hund4_q <= hund_full[HUND_W-1:0];
        near4_q <= near3_q;
        sat4_q  <= f3_q.saturated;
      end else begin
        cm4_q   <= '0;
        hund4_q <= '0;
        near4_q <= 1'b0;
        sat4_q  <= 1'b0;
      end
    end
  end

  assign out_valid_o           = v4_q;
  assign trigger_level_o       = trig4_q;
  assign result_valid_o        = res4_q;
  assign distance_cm_o         = cm4_q;
  assign distance_hundredths_o = hund4_q;
  assign near_flag_o           = near4_q;
  assign width_saturated_o     = sat4_q;

endmodule

// File: rtl/ultrasonic_echo_ranger.sv
// Top level of the ultrasonic echo ranger: stream ports, config registers.
// Depends on uer_pkg, uer_ctrl and uer_scale.
//
//  Channel   Direction  Handshake                     Payload
//  s_axis    in         s_axis_tvalid/s_axis_tready   echo_level, start_request
//  m_axis    out        m_axis_tvalid/m_axis_tready   trigger, result and distance
//  cfg       in         cfg_we_i (no back-pressure)   near threshold, trigger ticks
//
// One tick request is accepted per clock while the output is not stalled; each produces exactly one result.
// Each request passes the sequencer register, then four scaling stages
// (sample-count divide, x17, /1000 and /10 multiplies, hundredths and clamp).
// Every stage holds its own valid bit, so bubbles close up under output stall.
// Reset is immediate; there is no clearing pass.
`timescale 1ns / 1ps

module ultrasonic_echo_ranger #(
  parameter int unsigned SAMPLES    = 5,
  parameter int unsigned WIDTH_BITS = 20
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // bit 0 echo_level, bit 1 start_request, bits 7:2 zero
  input  logic [uer_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // bit 0 trigger_level, bit 1 result_valid, bits 16:2 distance_cm,
  // bits 23:17 distance_hundredths, bit 24 near_flag, bit 25 width_saturated
  output logic [uer_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  input  logic                              cfg_we_i,
  input  logic [uer_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [uer_pkg::CFG_DATA_W-1:0]    cfg_wdata_i
);
  import uer_pkg::*;

  localparam int unsigned SUM_W = WIDTH_BITS + 3;

  logic [THRESH_W-1:0] thresh_q;
  logic [TICKS_W-1:0]  ticks_q;

  logic                ctl_valid, ctl_ready;
  flags_t              ctl_flags;
  logic [SUM_W-1:0]    ctl_sum;

  logic                trig, res, near, sat;
  logic [CM_W-1:0]     cm;
  logic [HUND_W-1:0]   hund;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= THRESH_RST;
      ticks_q  <= TICKS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_NEAR_THRESHOLD: thresh_q <= cfg_wdata_i[THRESH_W-1:0];
        CFG_TRIGGER_TICKS:  ticks_q  <= cfg_wdata_i[TICKS_W-1:0];
        default: ;
      endcase
    end
  end

  uer_ctrl #(
    .SAMPLES    (SAMPLES),
    .WIDTH_BITS (WIDTH_BITS)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .trigger_ticks_i (ticks_q),
    .in_valid_i      (s_axis_tvalid),
    .in_ready_o      (s_axis_tready),
    .echo_level_i    (s_axis_tdata[0]),
    .start_request_i (s_axis_tdata[1]),
    .out_valid_o     (ctl_valid),
    .out_ready_i     (ctl_ready),
    .out_flags_o     (ctl_flags),
    .out_sum_o       (ctl_sum)
  );

  uer_scale #(
    .SAMPLES    (SAMPLES),
    .WIDTH_BITS (WIDTH_BITS)
  ) u_scale (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .near_threshold_i      (thresh_q),
    .in_valid_i            (ctl_valid),
    .in_ready_o            (ctl_ready),
    .in_flags_i            (ctl_flags),
    .in_sum_i              (ctl_sum),
    .out_valid_o           (m_axis_tvalid),
    .out_ready_i           (m_axis_tready),
    .trigger_level_o       (trig),
    .result_valid_o        (res),
    .distance_cm_o         (cm),
    .distance_hundredths_o (hund),
    .near_flag_o           (near),
    .width_saturated_o     (sat)
  );

  // Result packing, lowest field first
  assign m_axis_tdata = {6'd0, sat, near, hund, cm, res, trig};

  // A result tick never drives the trigger
  a_result_no_trigger: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[1]) |-> !m_axis_tdata[0])
    else $error("trigger high on a result tick");

  // Distance fields are zero on ticks without a result
  a_zero_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tdata[1]) |-> (m_axis_tdata[25:2] == 24'd0))
    else $error("distance fields set without a result");

  // Hundredths stay below one centimetre
  a_hund_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[23:17] < 7'd100))
    else $error("hundredths out of range");

  // An empty output stage never holds off the input
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

endmodule

// File: dv/tb_ultrasonic_echo_ranger.sv
// Self-checking testbench for ultrasonic_echo_ranger: stream driver, stream monitor,
// config writes and a per-tick reading predictor. Depends on uer_pkg and the RTL.
`timescale 1ns / 1ps

module tb_ultrasonic_echo_ranger;
  import uer_pkg::*;

  localparam int unsigned SAMPLES     = 5;
  localparam int unsigned WIDTH_BITS  = 20;
  localparam longint unsigned WMAX    = (64'd1 << WIDTH_BITS) - 64'd1;
  localparam int unsigned LATENCY     = 5;
  localparam int unsigned LONG_HOLD   = 400;
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned REQ_Q_DEPTH = 64;

  // One tick request: echo pin level and start request
  typedef struct packed {
    logic start;
    logic echo;
  } tick_t;

  // One reading, laid out as m_axis_tdata[25:0]
  typedef struct packed {
    logic                saturated;
    logic                near;
    logic [HUND_W-1:0]   dist_hund;
    logic [CM_W-1:0]     dist_cm;
    logic                ready;
    logic                trigger;
  } reading_t;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_PATTERN,
    RX_COIN
  } rx_mode_e;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata_i = '0;

  tick_t    tick_req_q[$];
  reading_t pending_readings_q[$];
  int unsigned pushed;
  int unsigned mismatches;
  int unsigned result_idx;
  int unsigned quiet_cycles;
  bit          steady_flow;
  bit          hold_req;

  // Predictor copy of the registers and sequencer state
  logic [THRESH_W-1:0] near_thr_cm = THRESH_RST;
  logic [TICKS_W-1:0]  trig_ticks  = TICKS_RST;
  phase_e              rng_phase   = PH_IDLE;
  logic [TICKS_W-1:0]  trig_cnt    = '0;
  longint unsigned     pulse_len;
  longint unsigned     len_sum;
  logic [SAMP_W-1:0]   pulses_done = '0;
  logic                sat_seen    = 1'b0;

  // Driver pacing and receiver stall state
  int unsigned gap_left;
  int unsigned burst_left;
  rx_mode_e    rx_mode;
  int unsigned mode_left;
  logic [7:0]  stall_pat;
  int unsigned hold_left;
  bit          hold_done;

  ultrasonic_echo_ranger #(
    .SAMPLES    (SAMPLES),
    .WIDTH_BITS (WIDTH_BITS)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // Clock and a single reset pulse
  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Advance the sequencer by one tick and return the reading it gives
  function automatic reading_t predict_reading(input logic echo, input logic start);
    reading_t        rd;
    int unsigned     len;
    longint unsigned avg;
    longint unsigned milli;
    longint unsigned cm;
    rd  = '0;
    len = (trig_ticks == 0) ? 1 : trig_ticks;
    case (rng_phase)
      PH_IDLE: begin
        if (start) begin
          rng_phase   = PH_TRIG;
          trig_cnt    = '0;
          pulse_len   = 0;
          len_sum     = 0;
          pulses_done = '0;
          sat_seen    = 1'b0;
        end
      end
      PH_TRIG: begin
        rd.trigger = 1'b1;
        trig_cnt   = trig_cnt + 8'd1;
        if (trig_cnt >= len || trig_cnt == 0) rng_phase = PH_WAIT;
      end
      PH_WAIT: begin
        // echo ignored until the trigger is done; first high tick is width one
        if (echo) begin
          pulse_len = 1;
          if (pulse_len >= WMAX) sat_seen = 1'b1;
          rng_phase = PH_MEAS;
        end
      end
      default: begin
        if (echo) begin
          if (pulse_len < WMAX) pulse_len++;
          if (pulse_len >= WMAX) sat_seen = 1'b1;
        end else begin
          len_sum     += pulse_len;
          pulse_len   = 0;
          pulses_done = pulses_done + 3'd1;
          if (pulses_done >= SAMPLES || pulses_done == 0) begin
            avg   = len_sum / SAMPLES;
            milli = avg * 17;
            cm    = milli / 1000;
            if (cm > CM_MAX) cm = CM_MAX;
            rd.ready     = 1'b1;
            rd.dist_cm   = cm[CM_W-1:0];
            rd.dist_hund = HUND_W'((milli / 10) % 100);
            rd.near      = (milli <= longint'(near_thr_cm) * 1000);
            rd.saturated = sat_seen;
            rng_phase    = PH_IDLE;
            len_sum      = 0;
            pulses_done  = '0;
            sat_seen     = 1'b0;
          end else begin
            rng_phase = PH_TRIG;
          end
          trig_cnt = '0;
        end
      end
    endcase
    return rd;
  endfunction

  // Driver: predicts each accepted request, then offers the next one in bursts
  always @(posedge clk_i or negedge rst_ni) begin
    tick_t nxt;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      gap_left      = 0;
      burst_left    = 1;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        pending_readings_q.push_back(predict_reading(s_axis_tdata[0], s_axis_tdata[1]));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (!steady_flow && gap_left != 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (tick_req_q.size() != 0) begin
          nxt = tick_req_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {6'b0, nxt.start, nxt.echo};
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 60);
            gap_left   = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 25)
                                                     : $urandom_range(0, 3);
          end else begin
            burst_left--;
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall modes that change every so often, plus one long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rx_mode   = RX_OPEN;
      mode_left = 50;
      stall_pat = 8'h5a;
      hold_left = 0;
      hold_done = 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_left = LONG_HOLD;
      hold_done = 1'b1;
      m_axis_tready <= 1'b0;
    end else if (steady_flow) begin
      m_axis_tready <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        rx_mode   = rx_mode_e'($urandom_range(0, 2));
        mode_left = $urandom_range(20, 200);
        stall_pat = 8'($urandom);
      end else begin
        mode_left--;
        stall_pat = {stall_pat[0], stall_pat[7:1]};
      end
      case (rx_mode)
        RX_OPEN:    m_axis_tready <= 1'b1;
        RX_PATTERN: m_axis_tready <= ~stall_pat[0];
        default:    m_axis_tready <= ($urandom_range(0, 2) != 0);
      endcase
    end
  end

  task automatic check_field(input string fname, input int unsigned want,
                             input int unsigned seen);
    if (want != seen) begin
      mismatches++;
      if (mismatches <= 10)
        $display("reading %0d: %s expected %0d, got %0d", result_idx, fname, want, seen);
    end
  endtask

  // Monitor: compare each accepted reading with the oldest prediction
  always @(posedge clk_i) begin
    reading_t want;
    reading_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = reading_t'(m_axis_tdata[25:0]);
      if (pending_readings_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("reading %0d: arrived with no request outstanding (%0h)",
                   result_idx, m_axis_tdata);
      end else begin
        want = pending_readings_q.pop_front();
        check_field("trigger_level", 32'(want.trigger), 32'(got.trigger));
        check_field("result_valid", 32'(want.ready), 32'(got.ready));
        check_field("distance_cm", 32'(want.dist_cm), 32'(got.dist_cm));
        check_field("distance_hundredths", 32'(want.dist_hund), 32'(got.dist_hund));
        check_field("near_flag", 32'(want.near), 32'(got.near));
        check_field("width_saturated", 32'(want.saturated), 32'(got.saturated));
        check_field("pad bits", 32'd0, 32'(m_axis_tdata[31:26]));
      end
      result_idx++;
    end
  end

  // Watchdog on cycles with no transfer on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  task automatic push_tick(input logic echo, input logic start);
    while (tick_req_q.size() >= REQ_Q_DEPTH) @(posedge clk_i);
    tick_req_q.push_back(tick_t'({start, echo}));
    pushed++;
  endtask

  // One measurement: trigger ticks, echo low wait, echo high width, one low tick
  task automatic push_pulse(input int unsigned len, input int unsigned lows,
                            input int unsigned width);
    repeat (len) push_tick(1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0);
    repeat (lows) push_tick(1'b0, $urandom_range(0, 3) == 0);
    repeat (width) push_tick(1'b1, $urandom_range(0, 3) == 0);
    push_tick(1'b0, $urandom_range(0, 3) == 0);
  endtask

  // Full burst; fixed_w of zero picks random widths up to maxw
  task automatic push_burst(input int unsigned len, input int unsigned maxw,
                            input int unsigned fixed_w);
    int unsigned w;
    push_tick(1'($urandom_range(0, 1)), 1'b1);
    repeat (SAMPLES) begin
      if (fixed_w != 0) w = fixed_w;
      else w = ($urandom_range(0, 7) == 0) ? maxw : $urandom_range(1, maxw);
      push_pulse(len, ($urandom_range(0, 2) == 0) ? $urandom_range(1, 4) : 0, w);
    end
  endtask

  // Mostly whole bursts, some noise and some bursts cut short
  task automatic run_random(input int unsigned len, input int unsigned maxw,
                            input int unsigned quota);
    int unsigned mark;
    mark = pushed;
    while (pushed - mark < quota) begin
      case ($urandom_range(0, 9))
        0: repeat ($urandom_range(1, 6))
             push_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        1: begin
          push_tick(1'b0, 1'b1);
          repeat ($urandom_range(0, len + 2)) push_tick(1'($urandom_range(0, 1)), 1'b0);
        end
        default: push_burst(len, maxw, 0);
      endcase
      repeat ($urandom_range(0, 3)) push_tick(1'($urandom_range(0, 1)), 1'b0);
    end
  endtask

  // Wait until no request is queued, offered or awaiting its reading
  task automatic wait_idle();
    do @(negedge clk_i);
    while (tick_req_q.size() != 0 || s_axis_tvalid || pending_readings_q.size() != 0);
    repeat (LATENCY + 2) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    if (idx == CFG_NEAR_THRESHOLD) near_thr_cm = val;
    else trig_ticks = val[TICKS_W-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] thr,
                           input logic [CFG_DATA_W-1:0] ticks);
    wait_idle();
    write_reg(CFG_NEAR_THRESHOLD, thr);
    write_reg(CFG_TRIGGER_TICKS, ticks);
  endtask

  // Stimulus
  initial begin
    int i;
    logic [CFG_DATA_W-1:0] thr_rand;
    wait (rst_ni === 1'b1);

    // Reset registers: idle ticks ignored, then a start and the 15-tick trigger
    // with echo and start toggling (both ignored while triggering)
    push_tick(1'b1, 1'b0);
    push_tick(1'b0, 1'b0);
    push_tick(1'b1, 1'b0);
    push_tick(1'b1, 1'b1);
    for (i = 0; i < 15; i++) push_tick(i[0], i[1]);

    // Now waiting for echo: a zero trigger length, written mid-burst, acts as one
    wait_idle();
    write_reg(CFG_TRIGGER_TICKS, 16'd0);
    push_tick(1'b1, 1'b0);
    push_tick(1'b0, 1'b1);
    push_pulse(1, 0, 1);
    push_pulse(1, 1, 2);
    push_pulse(1, 0, 1);
    push_pulse(1, 2, 3);

    // 1 cm threshold: averages 58 and 59 sit on either side of the near limit
    configure(16'd1, 16'd1);
    push_burst(1, 0, 58);
    push_burst(1, 0, 59);

    // Largest threshold and longest trigger, then one short pulse
    configure(16'hffff, {8'($urandom), 8'd255});
    push_tick(1'b0, 1'b1);
    repeat (255) push_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    push_pulse(0, 1, 3);

    // Zero threshold: near never set
    configure(16'd0, {8'($urandom), 8'd2});
    run_random(2, 12, 40);

    configure(16'd2, 16'd4);
    run_random(4, 20, 60);
    // leave a burst three ticks into its trigger
    push_tick(1'b0, 1'b1);
    repeat (3) push_tick(1'($urandom_range(0, 1)), 1'b0);

    // Shorter trigger written mid-trigger ends it on the next tick
    thr_rand = CFG_DATA_W'($urandom_range(0, 6));
    configure(thr_rand, 16'd2);
    push_pulse(1, 1, 5);
    repeat (SAMPLES - 1) push_pulse(2, $urandom_range(0, 2), $urandom_range(1, 20));
    run_random(2, 20, 30);
    // receiver holds off while requests keep coming
    hold_req = 1'b1;
    run_random(2, 20, 80);

    // Short pulses with no idling on either side
    configure(16'd20, 16'd1);
    steady_flow = 1'b1;
    push_tick(1'b0, 1'b1);
    repeat (SAMPLES) push_pulse(1, 0, $urandom_range(1, 3));
    wait_idle();
    steady_flow = 1'b0;

    if (pending_readings_q.size() != 0) begin
      mismatches++;
      $display("%0d predicted readings never arrived", pending_readings_q.size());
    end
    if (mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
